// File: rtl/zlib_stored_block_framer_assert.svh
// Assertion macros for the zlib stored-block framer.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef ZLIB_STORED_BLOCK_FRAMER_ASSERT_SVH
`define ZLIB_STORED_BLOCK_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define ZSBF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define ZSBF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`else
`define ZSBF_ASSERT(label, prop, msg)
`define ZSBF_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: rtl/zsbf_pkg.sv
// Shared types and constants of the zlib stored-block framer.
// No dependencies.
`default_nettype none
package zsbf_pkg;

    localparam int TOTAL_W   = 24;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LIMIT  = 2'd1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd16379;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One accepted byte, classified: which framing bytes surround it.
    typedef struct packed {
        logic [7:0]         data;
        logic               do_hdr;
        logic               do_blk;
        logic               blk_final;
        logic [LIMIT_W-1:0] blk_len;
        logic               data_bend;
        logic               do_trl;
        logic [15:0]        sum_high;
        logic [15:0]        sum_low;
    } job_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage
`default_nettype wire

// File: rtl/zsbf_front.sv
// Front end: configuration registers, stream/block bookkeeping, Adler-32.
// Depends on zsbf_pkg.
`default_nettype none
module zsbf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [zsbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zsbf_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                          accept,
    input  wire logic [7:0]                    data_byte,
    output zsbf_pkg::job_t                     job
);
    import zsbf_pkg::*;

    logic [TOTAL_W-1:0] total_len_reg;
    logic [LIMIT_W-1:0] block_lim_reg;
    logic               hdr_sent_reg, hdr_sent_next;
    logic [TOTAL_W-1:0] left_total_reg, left_total_next;
    logic [LIMIT_W-1:0] left_block_reg, left_block_next;
    logic [15:0]        sum_low_reg, sum_low_next;
    logic [15:0]        sum_high_reg, sum_high_next;

    logic [TOTAL_W-1:0] tot_eff, tot_dec;
    logic [LIMIT_W-1:0] blk_eff, blk_cur, blk_dec, lim, len;
    logic               new_blk;
    logic [15:0]        sl_base, sh_base;
    logic [16:0]        sl_sum, sh_sum;

    always_comb begin
        tot_eff = hdr_sent_reg ? left_total_reg
                : ((total_len_reg == '0) ? TOTAL_W'(1) : total_len_reg);
        blk_eff = hdr_sent_reg ? left_block_reg : '0;
        new_blk = (blk_eff == '0);
        lim     = (block_lim_reg == '0) ? LIMIT_W'(1) : block_lim_reg;
        len     = ({{(TOTAL_W-LIMIT_W){1'b0}}, lim} < tot_eff) ? lim
                : tot_eff[LIMIT_W-1:0];
        blk_cur = new_blk ? len : blk_eff;
        blk_dec = blk_cur - LIMIT_W'(1);
        tot_dec = tot_eff - TOTAL_W'(1);

        sl_base = hdr_sent_reg ? sum_low_reg  : 16'd1;
        sh_base = hdr_sent_reg ? sum_high_reg : 16'd0;
        sl_sum  = {1'b0, sl_base} + {9'd0, data_byte};
        if (sl_sum >= ADLER_MOD) sl_sum = sl_sum - ADLER_MOD;
        sh_sum  = {1'b0, sh_base} + sl_sum;
        if (sh_sum >= ADLER_MOD) sh_sum = sh_sum - ADLER_MOD;

        sum_low_next    = sl_sum[15:0];
        sum_high_next   = sh_sum[15:0];
        left_total_next = tot_dec;
        left_block_next = (tot_dec == '0) ? '0 : blk_dec;
        hdr_sent_next   = (tot_dec != '0);

        job.data      = data_byte;
        job.do_hdr    = !hdr_sent_reg;
        job.do_blk    = new_blk;
        job.blk_final = ({{(TOTAL_W-LIMIT_W){1'b0}}, len} == tot_eff);
        job.blk_len   = len;
        job.do_trl    = (tot_dec == '0);
        job.data_bend = (tot_dec != '0) && (blk_dec == '0);
        job.sum_high  = sh_sum[15:0];
        job.sum_low   = sl_sum[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_len_reg  <= TOTAL_RESET;
            block_lim_reg  <= LIMIT_RESET;
            hdr_sent_reg   <= 1'b0;
            left_total_reg <= '0;
            left_block_reg <= '0;
            sum_low_reg    <= 16'd1;
            sum_high_reg   <= 16'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TOTAL_LENGTH: total_len_reg <= cfg_wdata[TOTAL_W-1:0];
                    REG_BLOCK_LIMIT:  block_lim_reg <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                hdr_sent_reg   <= hdr_sent_next;
                left_total_reg <= left_total_next;
                left_block_reg <= left_block_next;
                sum_low_reg    <= sum_low_next;
                sum_high_reg   <= sum_high_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/zsbf_queue.sv
// Short job queue between the front and back ends.
// Depends on zsbf_pkg.
`default_nettype none
module zsbf_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire zsbf_pkg::job_t push_job,
    input  wire logic      pop,
    output zsbf_pkg::job_t head_job,
    output zsbf_pkg::q_stat_t stat
);
    import zsbf_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_job   = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/zsbf_back.sv
// Back end: expands each job into zlib stream bytes, one per cycle while m_ready allows.
// Depends on zsbf_pkg.
`default_nettype none
module zsbf_back (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire zsbf_pkg::job_t job,
    input  wire logic       job_valid,
    output logic            job_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_block_end,
    output logic            m_last,
    output logic            m_stream_end
);
    import zsbf_pkg::*;

    typedef enum logic [3:0] {
        ST_HDR0, ST_HDR1,
        ST_BLK0, ST_BLK1, ST_BLK2, ST_BLK3, ST_BLK4,
        ST_DATA,
        ST_TRL0, ST_TRL1, ST_TRL2, ST_TRL3
    } step_t;

    step_t       step_reg, step, step_nx;
    logic        mid_reg;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        bend_reg, last_reg, send_reg;
    logic        fire, done;
    logic [7:0]  out_b;
    logic [15:0] nlen;

    assign fire    = job_valid && (!valid_reg || m_ready);
    assign job_pop = fire && done;
    assign nlen    = ~job.blk_len;

    always_comb begin
        if (mid_reg)         step = step_reg;
        else if (job.do_hdr) step = ST_HDR0;
        else if (job.do_blk) step = ST_BLK0;
        else                 step = ST_DATA;

        step_nx = step;
        out_b   = job.data;
        done    = 1'b0;
        unique case (step)
            ST_HDR0: begin out_b = ZLIB_CMF; step_nx = ST_HDR1; end
            ST_HDR1: begin
                out_b   = ZLIB_FLG;
                step_nx = job.do_blk ? ST_BLK0 : ST_DATA;
            end
            ST_BLK0: begin out_b = {7'd0, job.blk_final}; step_nx = ST_BLK1; end
            ST_BLK1: begin out_b = job.blk_len[7:0];       step_nx = ST_BLK2; end
            ST_BLK2: begin out_b = job.blk_len[15:8];      step_nx = ST_BLK3; end
            ST_BLK3: begin out_b = nlen[7:0];              step_nx = ST_BLK4; end
            ST_BLK4: begin out_b = nlen[15:8];             step_nx = ST_DATA; end
            ST_DATA: begin
                out_b   = job.data;
                step_nx = ST_TRL0;
                done    = !job.do_trl;
            end
            ST_TRL0: begin out_b = job.sum_high[15:8]; step_nx = ST_TRL1; end
            ST_TRL1: begin out_b = job.sum_high[7:0];  step_nx = ST_TRL2; end
            ST_TRL2: begin out_b = job.sum_low[15:8];  step_nx = ST_TRL3; end
            ST_TRL3: begin out_b = job.sum_low[7:0];   done = 1'b1; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= ST_HDR0;
            mid_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                valid_reg <= 1'b1;
                byte_reg  <= out_b;
                bend_reg  <= (step == ST_DATA && job.data_bend) || (step == ST_TRL3);
                last_reg  <= done;
                send_reg  <= (step == ST_TRL3);
                mid_reg   <= !done;
                step_reg  <= step_nx;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_block_end  = bend_reg;
    assign m_last       = last_reg;
    assign m_stream_end = send_reg;

endmodule
`default_nettype wire

// File: rtl/zlib_stored_block_framer.sv
// Top level of the zlib stored-block framer: front end, job queue, back end.
// Depends on zsbf_pkg, zsbf_front, zsbf_queue, zsbf_back and the assert header.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | s_valid s_ready s_data_byte                  | in
//   result  | m_valid m_ready m_out_byte m_block_end       | out
//           | m_last m_stream_end                          |
//   config  | cfg_wr_en cfg_index cfg_wdata                | in
//
// Each accepted byte becomes one job in a four-deep queue; the back end sends
// one stream byte per cycle while m_ready allows, so a job yields 1 to 12 bytes
// (1 for a plain data byte, +2 for the zlib header, +5 for a block header, +4
// for the Adler-32 trailer). Output bandwidth of the single byte lane sets the
// rate. The front end takes a byte every cycle while the queue has room.
// Synchronous active-low reset empties the queue and restarts the stream.
// A stalled m_ready holds the output register; the queue absorbs input beats.
`default_nettype none
`include "zlib_stored_block_framer_assert.svh"
module zlib_stored_block_framer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [zsbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zsbf_pkg::CFG_DAT_W-1:0] cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_data_byte,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_block_end,
    output logic                                m_last,
    output logic                                m_stream_end
);
    import zsbf_pkg::*;

    job_t    new_job, head_job;
    q_stat_t q_stat;
    logic    accept, job_pop;

    // Take a beat whenever the queue has a free slot.
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    zsbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_byte (s_data_byte),
        .job       (new_job)
    );

    zsbf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_job (new_job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    zsbf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job          (head_job),
        .job_valid    (!q_stat.empty),
        .job_pop      (job_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_block_end  (m_block_end),
        .m_last       (m_last),
        .m_stream_end (m_stream_end)
    );

    // Trailer's final byte always closes the block and the job.
    `ZSBF_ASSERT(a_stream_end_closes, !(m_valid && m_stream_end) || (m_last && m_block_end), "stream end without last/block_end")
    // Never pop an empty queue.
    `ZSBF_ASSERT(a_no_underflow, !(job_pop && q_stat.empty), "job queue underflow")
    // Count moves by one on a lone push.
    `ZSBF_ASSERT_NEXT(a_push_count, accept && !job_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count did not advance")

endmodule
`default_nettype wire
